// ===== rtl/sms_pkg.sv =====
// sms_pkg: shared types, codes and constants of the sumo maneuver sequencer.
// No dependencies; imported by sms_front, sms_core and sumo_maneuver_sequencer.
package sms_pkg;

    // Stream word widths
    localparam int IN_DATA_W  = 120;  // 119 field bits, padded to whole bytes
    localparam int OUT_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Input word bit positions
    localparam int POS_TIME  = 0;
    localparam int POS_LINEL = 32;
    localparam int POS_LINER = 42;
    localparam int POS_OPPL  = 52;
    localparam int POS_OPPR  = 53;
    localparam int POS_RAW   = 54;
    localparam int POS_ADDR  = 86;
    localparam int POS_CMD   = 102;
    localparam int POS_REP   = 118;

    // Classified IR frame codes
    localparam logic [1:0] IR_NONE    = 2'd0;
    localparam logic [1:0] IR_START_R = 2'd1;
    localparam logic [1:0] IR_START_L = 2'd2;
    localparam logic [1:0] IR_STOP    = 2'd3;

    // Sequencer modes
    localparam logic [3:0] MODE_SEARCH       = 4'd0;
    localparam logic [3:0] MODE_INIT         = 4'd1;
    localparam logic [3:0] MODE_INIT_STOP    = 4'd2;
    localparam logic [3:0] MODE_BOTH_BACKUP  = 4'd3;
    localparam logic [3:0] MODE_BOTH_SPIN    = 4'd4;
    localparam logic [3:0] MODE_LEFT_BACKUP  = 4'd5;
    localparam logic [3:0] MODE_LEFT_PIVOT   = 4'd6;
    localparam logic [3:0] MODE_RIGHT_BACKUP = 4'd7;
    localparam logic [3:0] MODE_RIGHT_PIVOT  = 4'd8;
    localparam logic [3:0] MODE_TURN_STOP    = 4'd9;

    // Motor commands
    localparam logic [3:0] CMD_HOLD     = 4'd0;
    localparam logic [3:0] CMD_STOP     = 4'd1;
    localparam logic [3:0] CMD_SPIN_CW  = 4'd2;
    localparam logic [3:0] CMD_SPIN_CCW = 4'd3;
    localparam logic [3:0] CMD_PIVOT_R  = 4'd4;
    localparam logic [3:0] CMD_PIVOT_L  = 4'd5;
    localparam logic [3:0] CMD_BACK     = 4'd6;
    localparam logic [3:0] CMD_LEFT     = 4'd7;
    localparam logic [3:0] CMD_RIGHT    = 4'd8;
    localparam logic [3:0] CMD_FWD      = 4'd9;

    // Fixed recovery speeds
    localparam logic [7:0] SPD_BACK_BOTH = 8'd200;
    localparam logic [7:0] SPD_BACK_SIDE = 8'd100;
    localparam logic [7:0] SPD_TURN      = 8'd180;

    // Known remote frames
    localparam logic [31:0] RAW_START_R0 = 32'h8505_0080;
    localparam logic [31:0] RAW_START_R1 = 32'h0000_A020;
    localparam logic [31:0] RAW_START_R2 = 32'hA020_0080;
    localparam logic [31:0] RAW_START_L0 = 32'hB232_0080;
    localparam logic [31:0] RAW_START_L1 = 32'h0000_B232;
    localparam logic [31:0] RAW_STOP0    = 32'hBF3F_0080;
    localparam logic [31:0] RAW_STOP1    = 32'h0000_BF3F;
    localparam logic [31:0] RAW_STOP2    = 32'hBE3E_0080;
    localparam logic [31:0] RAW_STOP3    = 32'h0000_BE3E;
    localparam logic [15:0] HALF_STOP0   = 16'hBF3F;
    localparam logic [15:0] HALF_STOP1   = 16'hBE3E;
    localparam logic [7:0]  BYTE_STOP0   = 8'h3F;
    localparam logic [7:0]  BYTE_STOP1   = 8'h3E;
    localparam logic [15:0] ADDR_STOP    = 16'h0080;

    // floor(t / 500) = floor((t >> 2) * BLINK_RECIP / 2^37), exact for t < 2^32
    localparam logic [30:0] BLINK_RECIP = 31'd1099511628;
    localparam int          BLINK_SHIFT = 37;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_THR   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_SPD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INIT_SPIN  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BACK_BOTH  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BACK_SIDE  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN       = 3'd7;

    // Item as it leaves the front stage
    typedef struct packed {
        logic        action;     // 0 tick, 1 IR frame
        logic [31:0] time_ms;
        logic [9:0]  line_left;
        logic [9:0]  line_right;
        logic        opp_left_seen;
        logic        opp_right_seen;
        logic        ir_repeat;
        logic [1:0]  ir_class;   // classification without the repeat rule
        logic        blink;      // bit 0 of time_ms / 500
    } t_item;

    // Stage handshake toward the core
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

// ===== rtl/sms_front.sv =====
// sms_front: input register stage; classifies IR frames and derives the blink bit.
// Depends on sms_pkg.
module sms_front
    import sms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic                  i_advance,
    input  logic [IN_DATA_W-1:0]  i_tdata,
    input  logic                  i_tuser,
    output logic                  o_valid,
    output t_item                 o_item
);

    logic [31:0] w_raw;
    logic [15:0] w_addr;
    logic [15:0] w_cmd;
    logic [31:0] w_time;
    logic [60:0] w_prod;
    logic        w_half;
    logic        w_byte;
    logic        w_stop;
    logic        w_start_r;
    logic        w_start_l;
    logic [1:0]  w_class;

    logic        r_valid;
    t_item       r_item;

    assign w_time = i_tdata[POS_TIME +: 32];
    assign w_raw  = i_tdata[POS_RAW  +: 32];
    assign w_addr = i_tdata[POS_ADDR +: 16];
    assign w_cmd  = i_tdata[POS_CMD  +: 16];

    // Reciprocal multiply for the 500 ms blink phase
    assign w_prod = 61'(w_time[31:2]) * 61'(BLINK_RECIP);

    // Stop patterns: whole word, either half, any byte, or address plus command
    assign w_half = (w_raw[15:0]  == HALF_STOP0) || (w_raw[31:16] == HALF_STOP0) ||
                    (w_raw[15:0]  == HALF_STOP1) || (w_raw[31:16] == HALF_STOP1);
    assign w_byte = (w_raw[7:0]   == BYTE_STOP0) || (w_raw[15:8]  == BYTE_STOP0) ||
                    (w_raw[23:16] == BYTE_STOP0) || (w_raw[31:24] == BYTE_STOP0) ||
                    (w_raw[7:0]   == BYTE_STOP1) || (w_raw[15:8]  == BYTE_STOP1) ||
                    (w_raw[23:16] == BYTE_STOP1) || (w_raw[31:24] == BYTE_STOP1);
    assign w_stop = (w_raw == RAW_STOP0) || (w_raw == RAW_STOP1) ||
                    (w_raw == RAW_STOP2) || (w_raw == RAW_STOP3) || w_half || w_byte ||
                    (((w_addr == ADDR_STOP) || (w_addr == 16'd0)) &&
                     ((w_cmd == 16'(BYTE_STOP0)) || (w_cmd == 16'(BYTE_STOP1)) ||
                      (w_cmd == HALF_STOP0) || (w_cmd == HALF_STOP1)));
    assign w_start_r = (w_raw == RAW_START_R0) || (w_raw == RAW_START_R1) ||
                       (w_raw == RAW_START_R2);
    assign w_start_l = (w_raw == RAW_START_L0) || (w_raw == RAW_START_L1);

    // Priority: stop, then start right, then start left
    always_comb begin
        if (w_stop) begin
            w_class = IR_STOP;
        end else if (w_start_r) begin
            w_class = IR_START_R;
        end else if (w_start_l) begin
            w_class = IR_START_L;
        end else begin
            w_class = IR_NONE;
        end
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.action         <= i_tuser;
            r_item.time_ms        <= w_time;
            r_item.line_left      <= i_tdata[POS_LINEL +: 10];
            r_item.line_right     <= i_tdata[POS_LINER +: 10];
            r_item.opp_left_seen  <= i_tdata[POS_OPPL];
            r_item.opp_right_seen <= i_tdata[POS_OPPR];
            r_item.ir_repeat      <= i_tdata[POS_REP];
            r_item.ir_class       <= w_class;
            r_item.blink          <= w_prod[BLINK_SHIFT];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/sms_core.sv =====
// sms_core: configuration registers, sequencer state and the result register.
// Depends on sms_pkg.
module sms_core
    import sms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  t_stage_ctl             i_ctl,
    input  t_item                  i_item,
    output logic                   o_valid,
    output logic [OUT_DATA_W-1:0]  o_tdata
);

    // Configuration
    logic [9:0]  r_edge_thr;
    logic [3:0]  r_debounce;
    logic [7:0]  r_base_spd;
    logic [7:0]  r_search_spd;
    logic [15:0] r_init_spin;
    logic [15:0] r_back_both;
    logic [15:0] r_back_side;
    logic [15:0] r_turn;

    // Sequencer state
    logic        r_armed,        n_armed;
    logic        r_start_right,  n_start_right;
    logic        r_initial_done, n_initial_done;
    logic [3:0]  r_mode,         n_mode;
    logic [31:0] r_mark,         n_mark;
    logic [3:0]  r_lcnt,         n_lcnt;
    logic [3:0]  r_rcnt,         n_rcnt;
    logic [1:0]  r_last_ir,      n_last_ir;
    logic        r_red,          n_red;
    logic        r_green,        n_green;

    // Result register
    logic        r_out_valid;
    logic [3:0]  r_out_cmd,  n_cmd;
    logic [7:0]  r_out_spd,  n_spd;
    logic        r_out_red;
    logic        r_out_green;
    logic [1:0]  r_out_act,  n_act;

    logic        w_take;
    logic [31:0] w_delta;
    logic        w_le;
    logic        w_re;
    logic        w_ld;
    logic        w_rd;

    assign w_take  = i_ctl.valid && i_ctl.advance;
    assign w_delta = i_item.time_ms - r_mark;
    assign w_le    = i_item.line_left  < r_edge_thr;
    assign w_re    = i_item.line_right < r_edge_thr;

    // Next state and result for the item in the front stage
    always_comb begin
        n_armed        = r_armed;
        n_start_right  = r_start_right;
        n_initial_done = r_initial_done;
        n_mode         = r_mode;
        n_mark         = r_mark;
        n_lcnt         = r_lcnt;
        n_rcnt         = r_rcnt;
        n_last_ir      = r_last_ir;
        n_red          = r_red;
        n_green        = r_green;
        n_cmd          = CMD_HOLD;
        n_spd          = 8'd0;
        n_act          = IR_NONE;
        w_ld           = 1'b0;
        w_rd           = 1'b0;

        if (i_item.action) begin
            // IR frame: repeat reuses the last action
            if (i_item.ir_repeat && (r_last_ir != IR_NONE)) begin
                n_act = r_last_ir;
            end else begin
                n_act = i_item.ir_class;
            end
            n_last_ir = n_act;
            if (n_act == IR_STOP) begin
                n_armed        = 1'b0;
                n_initial_done = 1'b0;
                n_mode         = MODE_SEARCH;
                n_cmd          = CMD_STOP;
            end else if (n_act != IR_NONE) begin
                n_start_right  = (n_act == IR_START_R);
                n_armed        = 1'b1;
                n_initial_done = 1'b0;
                n_mode         = MODE_SEARCH;
            end
        end else if (!r_armed) begin
            // Disarmed tick: stopped, red blinks
            n_cmd   = CMD_STOP;
            n_red   = i_item.blink;
            n_green = 1'b0;
        end else begin
            n_red   = 1'b0;
            n_green = 1'b1;
            unique case (r_mode) inside
                MODE_INIT: begin
                    n_cmd  = r_start_right ? CMD_SPIN_CW : CMD_SPIN_CCW;
                    n_spd  = r_search_spd;
                    n_mark = i_item.time_ms;
                    n_mode = MODE_INIT_STOP;
                end
                MODE_INIT_STOP: begin
                    if (w_delta >= 32'(r_init_spin)) begin
                        n_cmd  = CMD_STOP;
                        n_mark = i_item.time_ms;
                        n_mode = MODE_SEARCH;
                    end
                end
                MODE_BOTH_BACKUP: begin
                    n_cmd  = CMD_BACK;
                    n_spd  = SPD_BACK_BOTH;
                    n_mark = i_item.time_ms;
                    n_mode = MODE_BOTH_SPIN;
                end
                MODE_BOTH_SPIN: begin
                    if (w_delta >= 32'(r_back_both)) begin
                        n_cmd  = CMD_SPIN_CW;
                        n_spd  = SPD_TURN;
                        n_mark = i_item.time_ms;
                        n_mode = MODE_TURN_STOP;
                    end
                end
                MODE_LEFT_BACKUP, MODE_RIGHT_BACKUP: begin
                    n_cmd  = CMD_BACK;
                    n_spd  = SPD_BACK_SIDE;
                    n_mark = i_item.time_ms;
                    n_mode = (r_mode == MODE_LEFT_BACKUP) ? MODE_LEFT_PIVOT
                                                          : MODE_RIGHT_PIVOT;
                end
                MODE_LEFT_PIVOT, MODE_RIGHT_PIVOT: begin
                    if (w_delta >= 32'(r_back_side)) begin
                        n_cmd  = (r_mode == MODE_LEFT_PIVOT) ? CMD_PIVOT_R : CMD_PIVOT_L;
                        n_spd  = SPD_TURN;
                        n_mark = i_item.time_ms;
                        n_mode = MODE_TURN_STOP;
                    end
                end
                MODE_TURN_STOP: begin
                    if (w_delta >= 32'(r_turn)) begin
                        n_cmd  = CMD_STOP;
                        n_mark = i_item.time_ms;
                        n_mode = MODE_SEARCH;
                    end
                end
                MODE_SEARCH: begin
                    if (!r_initial_done) begin
                        n_initial_done = 1'b1;
                        n_mode         = MODE_INIT;
                    end else if (w_le || w_re) begin
                        // Ring edge: pick the recovery by which side saw it
                        if (w_le && w_re) begin
                            n_mode = MODE_BOTH_BACKUP;
                        end else if (w_le) begin
                            n_mode = MODE_LEFT_BACKUP;
                        end else begin
                            n_mode = MODE_RIGHT_BACKUP;
                        end
                    end else begin
                        // Up/down debounce, saturating at the debounce level
                        if (i_item.opp_left_seen) begin
                            if (r_lcnt < r_debounce) n_lcnt = r_lcnt + 4'd1;
                        end else if (r_lcnt != 4'd0) begin
                            n_lcnt = r_lcnt - 4'd1;
                        end
                        if (i_item.opp_right_seen) begin
                            if (r_rcnt < r_debounce) n_rcnt = r_rcnt + 4'd1;
                        end else if (r_rcnt != 4'd0) begin
                            n_rcnt = r_rcnt - 4'd1;
                        end
                        w_ld = (n_lcnt >= r_debounce);
                        w_rd = (n_rcnt >= r_debounce);
                        if (w_ld || w_rd) begin
                            if (w_ld && !w_rd) begin
                                n_cmd = CMD_LEFT;
                            end else if (w_rd && !w_ld) begin
                                n_cmd = CMD_RIGHT;
                            end else begin
                                n_cmd = CMD_FWD;
                            end
                            n_spd = r_base_spd;
                        end else begin
                            n_cmd = CMD_SPIN_CW;
                            n_spd = r_search_spd;
                        end
                    end
                end
                default: begin
                    // unreachable modes hold the motors
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_thr   <= 10'd900;
            r_debounce   <= 4'd2;
            r_base_spd   <= 8'd200;
            r_search_spd <= 8'd100;
            r_init_spin  <= 16'd350;
            r_back_both  <= 16'd250;
            r_back_side  <= 16'd150;
            r_turn       <= 16'd300;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_EDGE_THR:   r_edge_thr   <= i_cfg_wdata[9:0];
                REG_DEBOUNCE:   r_debounce   <= i_cfg_wdata[3:0];
                REG_BASE_SPD:   r_base_spd   <= i_cfg_wdata[7:0];
                REG_SEARCH_SPD: r_search_spd <= i_cfg_wdata[7:0];
                REG_INIT_SPIN:  r_init_spin  <= i_cfg_wdata;
                REG_BACK_BOTH:  r_back_both  <= i_cfg_wdata;
                REG_BACK_SIDE:  r_back_side  <= i_cfg_wdata;
                REG_TURN:       r_turn       <= i_cfg_wdata;
                default:        r_turn       <= r_turn;
            endcase
        end
    end

    // Sequencer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed        <= 1'b0;
            r_start_right  <= 1'b0;
            r_initial_done <= 1'b0;
            r_mode         <= MODE_SEARCH;
            r_mark         <= 32'd0;
            r_lcnt         <= 4'd0;
            r_rcnt         <= 4'd0;
            r_last_ir      <= IR_NONE;
            r_red          <= 1'b1;
            r_green        <= 1'b0;
        end else if (w_take) begin
            r_armed        <= n_armed;
            r_start_right  <= n_start_right;
            r_initial_done <= n_initial_done;
            r_mode         <= n_mode;
            r_mark         <= n_mark;
            r_lcnt         <= n_lcnt;
            r_rcnt         <= n_rcnt;
            r_last_ir      <= n_last_ir;
            r_red          <= n_red;
            r_green        <= n_green;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_out_valid <= i_ctl.valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_cmd   <= n_cmd;
            r_out_spd   <= n_spd;
            r_out_red   <= n_red;
            r_out_green <= n_green;
            r_out_act   <= n_act;
        end
    end

    assign o_valid = r_out_valid;
    assign o_tdata = {r_out_act, r_out_green, r_out_red, r_out_spd, r_out_cmd};

endmodule

// ===== rtl/sumo_maneuver_sequencer.sv =====
// sumo_maneuver_sequencer: top level of the robot drive sequencer.
// Depends on sms_pkg, sms_front and sms_core.
//
//  Channel  | Ports                       | Word contents
//  ---------+-----------------------------+-----------------------------------------
//  in       | i_s_axis_t*, o_s_axis_tready| tuser action; tdata time, lines, opp, IR
//  out      | o_m_axis_t*, i_m_axis_tready| cmd, speed, red, green, ir_action
//  config   | i_cfg_wr_en/addr/wdata      | eight registers, write only
//
// Two-stage pipeline: an input register stage (IR classification and blink
// phase multiply) and the result register (state update). One word is
// accepted every cycle while the output is taken.
// A stall on the output holds both stages; the input stage still takes a
// word while it is empty. Reset is synchronous, active low, and loads the
// register defaults.
module sumo_maneuver_sequencer
    import sms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // time[31:0], line_left[41:32], line_right[51:42], opp_left_seen[52],
    // opp_right_seen[53], raw_code[85:54], ir_address[101:86],
    // ir_command[117:102], ir_repeat[118], zero[119]
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    // action[0]
    input  logic                   i_s_axis_tuser,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // motor_cmd[3:0], motor_speed[11:4], red_lamp[12], green_lamp[13],
    // ir_action[15:14]
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic       w_s1_valid;
    logic       w_load;
    t_item      w_item;
    t_stage_ctl w_ctl;

    // Pipeline moves when the result register is empty or being taken
    assign w_ctl.advance   = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_ctl.valid     = w_s1_valid;
    assign o_s_axis_tready = !w_s1_valid || w_ctl.advance;
    assign w_load          = i_s_axis_tvalid && o_s_axis_tready;

    sms_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_advance (w_ctl.advance),
        .i_tdata   (i_s_axis_tdata),
        .i_tuser   (i_s_axis_tuser),
        .o_valid   (w_s1_valid),
        .o_item    (w_item)
    );

    sms_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (w_ctl),
        .i_item      (w_item),
        .o_valid     (o_m_axis_tvalid),
        .o_tdata     (o_m_axis_tdata)
    );

endmodule

// ===== tb/tb_sumo_maneuver_sequencer.sv =====
`timescale 1ns / 100ps
// tb_sumo_maneuver_sequencer: self-checking bench for the robot drive sequencer.
// Depends on sms_pkg and sumo_maneuver_sequencer; a behavioral predictor in the
// maneuver_checker class tracks arming, recovery and search state per word.

import sms_pkg::*;

// One input word, unpacked
typedef struct {
    bit        is_frame;
    bit [31:0] time_ms;
    bit [9:0]  line_left;
    bit [9:0]  line_right;
    bit        opp_left;
    bit        opp_right;
    bit [31:0] raw_code;
    bit [15:0] ir_address;
    bit [15:0] ir_command;
    bit        ir_repeat;
} t_drive_item;

// Predicts the result word of every accepted input word and checks outputs
class maneuver_checker;
    // register copies
    logic [9:0]  edge_thr;
    logic [3:0]  debounce;
    logic [7:0]  base_spd;
    logic [7:0]  search_spd;
    logic [15:0] init_spin_ms;
    logic [15:0] back_both_ms;
    logic [15:0] back_side_ms;
    logic [15:0] turn_ms;

    // robot state
    bit          armed;
    bit          start_right;
    bit          initial_done;
    logic [3:0]  mode;
    logic [31:0] mark_time;
    logic [3:0]  left_cnt;
    logic [3:0]  right_cnt;
    logic [1:0]  last_ir;
    bit          red_level;
    bit          green_level;

    logic [15:0] expected_words[$];
    int          errors;

    function void clear();
        edge_thr     = 10'd900;
        debounce     = 4'd2;
        base_spd     = 8'd200;
        search_spd   = 8'd100;
        init_spin_ms = 16'd350;
        back_both_ms = 16'd250;
        back_side_ms = 16'd150;
        turn_ms      = 16'd300;
        armed        = 1'b0;
        start_right  = 1'b0;
        initial_done = 1'b0;
        mode         = MODE_SEARCH;
        mark_time    = '0;
        left_cnt     = '0;
        right_cnt    = '0;
        last_ir      = IR_NONE;
        red_level    = 1'b1;
        green_level  = 1'b0;
        expected_words.delete();
        errors       = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_EDGE_THR:   edge_thr     = val[9:0];
            REG_DEBOUNCE:   debounce     = val[3:0];
            REG_BASE_SPD:   base_spd     = val[7:0];
            REG_SEARCH_SPD: search_spd   = val[7:0];
            REG_INIT_SPIN:  init_spin_ms = val;
            REG_BACK_BOTH:  back_both_ms = val;
            REG_BACK_SIDE:  back_side_ms = val;
            REG_TURN:       turn_ms      = val;
            default: ;
        endcase
    endfunction

    function void take_item(t_drive_item it);
        logic [3:0]  cmd;
        logic [7:0]  spd;
        logic [1:0]  act;
        bit          stop_hit;
        bit          le, re, ld, rd;
        logic [31:0] span;
        logic [31:0] blink_q;
        cmd  = CMD_HOLD;
        spd  = '0;
        act  = IR_NONE;
        span = it.time_ms - mark_time;
        if (it.is_frame) begin
            // stop matches whole words, either half, any byte, or address plus command
            stop_hit = it.raw_code == RAW_STOP0 || it.raw_code == RAW_STOP1 ||
                       it.raw_code == RAW_STOP2 || it.raw_code == RAW_STOP3;
            for (int h = 0; h < 2; h++)
                if (it.raw_code[h*16 +: 16] == HALF_STOP0 ||
                    it.raw_code[h*16 +: 16] == HALF_STOP1)
                    stop_hit = 1'b1;
            for (int b = 0; b < 4; b++)
                if (it.raw_code[b*8 +: 8] == BYTE_STOP0 || it.raw_code[b*8 +: 8] == BYTE_STOP1)
                    stop_hit = 1'b1;
            if ((it.ir_address == ADDR_STOP || it.ir_address == 16'h0000) &&
                (it.ir_command == {8'h00, BYTE_STOP0} || it.ir_command == {8'h00, BYTE_STOP1} ||
                 it.ir_command == HALF_STOP0 || it.ir_command == HALF_STOP1))
                stop_hit = 1'b1;

            if (it.ir_repeat && last_ir != IR_NONE)
                act = last_ir;
            else if (stop_hit)
                act = IR_STOP;
            else if (it.raw_code == RAW_START_R0 || it.raw_code == RAW_START_R1 ||
                     it.raw_code == RAW_START_R2)
                act = IR_START_R;
            else if (it.raw_code == RAW_START_L0 || it.raw_code == RAW_START_L1)
                act = IR_START_L;
            last_ir = act;

            if (act == IR_STOP) begin
                armed        = 1'b0;
                initial_done = 1'b0;
                mode         = MODE_SEARCH;
                cmd          = CMD_STOP;
            end else if (act == IR_START_R || act == IR_START_L) begin
                start_right  = (act == IR_START_R);
                armed        = 1'b1;
                initial_done = 1'b0;
                mode         = MODE_SEARCH;
            end
        end else if (armed) begin
            red_level   = 1'b0;
            green_level = 1'b1;
            case (mode) inside
                MODE_INIT: begin
                    cmd       = start_right ? CMD_SPIN_CW : CMD_SPIN_CCW;
                    spd       = search_spd;
                    mark_time = it.time_ms;
                    mode      = MODE_INIT_STOP;
                end
                MODE_INIT_STOP: begin
                    if (span >= {16'h0, init_spin_ms}) begin
                        cmd       = CMD_STOP;
                        mark_time = it.time_ms;
                        mode      = MODE_SEARCH;
                    end
                end
                MODE_BOTH_BACKUP: begin
                    cmd       = CMD_BACK;
                    spd       = SPD_BACK_BOTH;
                    mark_time = it.time_ms;
                    mode      = MODE_BOTH_SPIN;
                end
                MODE_BOTH_SPIN: begin
                    if (span >= {16'h0, back_both_ms}) begin
                        cmd       = CMD_SPIN_CW;
                        spd       = SPD_TURN;
                        mark_time = it.time_ms;
                        mode      = MODE_TURN_STOP;
                    end
                end
                MODE_LEFT_BACKUP, MODE_RIGHT_BACKUP: begin
                    cmd       = CMD_BACK;
                    spd       = SPD_BACK_SIDE;
                    mark_time = it.time_ms;
                    if (mode == MODE_LEFT_BACKUP)
                        mode = MODE_LEFT_PIVOT;
                    else
                        mode = MODE_RIGHT_PIVOT;
                end
                MODE_LEFT_PIVOT, MODE_RIGHT_PIVOT: begin
                    if (span >= {16'h0, back_side_ms}) begin
                        cmd       = (mode == MODE_LEFT_PIVOT) ? CMD_PIVOT_R : CMD_PIVOT_L;
                        spd       = SPD_TURN;
                        mark_time = it.time_ms;
                        mode      = MODE_TURN_STOP;
                    end
                end
                MODE_TURN_STOP: begin
                    if (span >= {16'h0, turn_ms}) begin
                        cmd       = CMD_STOP;
                        mark_time = it.time_ms;
                        mode      = MODE_SEARCH;
                    end
                end
                MODE_SEARCH: begin
                    if (!initial_done) begin
                        initial_done = 1'b1;
                        mode         = MODE_INIT;
                    end else begin
                        le = it.line_left < edge_thr;
                        re = it.line_right < edge_thr;
                        if (le && re)
                            mode = MODE_BOTH_BACKUP;
                        else if (le)
                            mode = MODE_LEFT_BACKUP;
                        else if (re)
                            mode = MODE_RIGHT_BACKUP;
                        else begin
                            // up/down debounce, saturating at the configured level
                            if (it.opp_left) begin
                                if (left_cnt < debounce) left_cnt++;
                            end else if (left_cnt != 0) left_cnt--;
                            if (it.opp_right) begin
                                if (right_cnt < debounce) right_cnt++;
                            end else if (right_cnt != 0) right_cnt--;
                            ld = left_cnt >= debounce;
                            rd = right_cnt >= debounce;
                            if (ld || rd) begin
                                if (ld && !rd)
                                    cmd = CMD_LEFT;
                                else if (rd && !ld)
                                    cmd = CMD_RIGHT;
                                else
                                    cmd = CMD_FWD;
                                spd = base_spd;
                            end else begin
                                cmd = CMD_SPIN_CW;
                                spd = search_spd;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end else begin
            // disarmed: stop, red blinks with a 500 ms half period
            cmd         = CMD_STOP;
            blink_q     = it.time_ms / 32'd500;
            red_level   = blink_q[0];
            green_level = 1'b0;
        end
        expected_words.push_back({act, green_level, red_level, spd, cmd});
    endfunction

    function void match_word(logic [15:0] got);
        logic [15:0] want;
        if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("output word %h with nothing expected", got);
            return;
        end
        want = expected_words.pop_front();
        if (got[3:0] !== want[3:0] || got[11:4] !== want[11:4] || got[12] !== want[12] ||
            got[13] !== want[13] || got[15:14] !== want[15:14]) begin
            errors++;
            if (errors <= 10)
                $display("wrong word: cmd %0d/%0d speed %0d/%0d red %b/%b green %b/%b ir %0d/%0d",
                         want[3:0], got[3:0], want[11:4], got[11:4], want[12], got[12],
                         want[13], got[13], want[15:14], got[15:14]);
        end
    endfunction
endclass

module tb_sumo_maneuver_sequencer;

    localparam int WATCHDOG_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // time, line_left, line_right, opp l/r, raw, addr, cmd, repeat
    logic                  i_s_axis_tuser;   // action
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // motor_cmd, motor_speed, red_lamp, green_lamp, ir_action
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    maneuver_checker tracker;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              idle_cycles;
    logic [31:0]     now_ms;
    bit              opp_l_state;
    bit              opp_r_state;

    sumo_maneuver_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: check taken words, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.match_word(o_m_axis_tdata);
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Cycles without any traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("sumo_maneuver_sequencer: mismatch");
        $finish;
    end

    function automatic t_drive_item tick_item(logic [31:0] t, logic [9:0] ll, logic [9:0] lr,
                                              bit ol, bit orr);
        t_drive_item it;
        it.is_frame   = 1'b0;
        it.time_ms    = t;
        it.line_left  = ll;
        it.line_right = lr;
        it.opp_left   = ol;
        it.opp_right  = orr;
        // frame fields are don't-care on ticks
        it.raw_code   = $urandom;
        it.ir_address = 16'($urandom_range(16'hFFFF));
        it.ir_command = 16'($urandom_range(16'hFFFF));
        it.ir_repeat  = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_drive_item frame_item(logic [31:0] raw, logic [15:0] addr,
                                               logic [15:0] cmd, bit rep);
        t_drive_item it;
        it.is_frame   = 1'b1;
        it.time_ms    = $urandom;
        it.line_left  = 10'($urandom_range(1023));
        it.line_right = 10'($urandom_range(1023));
        it.opp_left   = 1'($urandom_range(1));
        it.opp_right  = 1'($urandom_range(1));
        it.raw_code   = raw;
        it.ir_address = addr;
        it.ir_command = cmd;
        it.ir_repeat  = rep;
        return it;
    endfunction

    // Line reading: mostly clear of the edge, sometimes on it, sometimes anything
    function automatic logic [9:0] line_pick(logic [9:0] thr);
        int roll;
        roll = $urandom_range(99);
        if (roll < 5 && thr != 0)
            return 10'($urandom_range(thr - 10'd1));
        if (roll < 12)
            return 10'($urandom_range(1023));
        return 10'($urandom_range(1023, thr));
    endfunction

    task automatic send_item(input t_drive_item it);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[POS_TIME  +: 32] = it.time_ms;
        word[POS_LINEL +: 10] = it.line_left;
        word[POS_LINER +: 10] = it.line_right;
        word[POS_OPPL]        = it.opp_left;
        word[POS_OPPR]        = it.opp_right;
        word[POS_RAW   +: 32] = it.raw_code;
        word[POS_ADDR  +: 16] = it.ir_address;
        word[POS_CMD   +: 16] = it.ir_command;
        word[POS_REP]         = it.ir_repeat;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.is_frame;
        i_s_axis_tdata  <= word;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        tracker.take_item(it);
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_one(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tracker.write_reg(idx, val);
    endtask

    task automatic load_regs(input logic [15:0] thr, input logic [15:0] deb,
                             input logic [15:0] base, input logic [15:0] search,
                             input logic [15:0] init_ms, input logic [15:0] both_ms,
                             input logic [15:0] side_ms, input logic [15:0] trn_ms);
        write_one(REG_EDGE_THR, thr);
        write_one(REG_DEBOUNCE, deb);
        write_one(REG_BASE_SPD, base);
        write_one(REG_SEARCH_SPD, search);
        write_one(REG_INIT_SPIN, init_ms);
        write_one(REG_BACK_BOTH, both_ms);
        write_one(REG_BACK_SIDE, side_ms);
        write_one(REG_TURN, trn_ms);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly armed play: starts, ticks with advancing time, some stops and noise
    task automatic run_random(input int count);
        t_drive_item it;
        int          pick;
        int          k;
        logic [31:0] raw;
        logic [15:0] addr;
        logic [15:0] cmd;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            raw  = $urandom;
            addr = 16'($urandom_range(16'hFFFF));
            cmd  = 16'($urandom_range(16'hFFFF));
            k    = $urandom_range(3);
            if (pick < 7) begin
                case ($urandom_range(4))
                    0: raw = RAW_START_R0;
                    1: raw = RAW_START_R1;
                    2: raw = RAW_START_R2;
                    3: raw = RAW_START_L0;
                    default: raw = RAW_START_L1;
                endcase
                it = frame_item(raw, addr, cmd, ($urandom_range(7) == 0));
            end else if (pick < 10) begin
                case ($urandom_range(3))
                    0: begin
                        case (k)
                            0: raw = RAW_STOP0;
                            1: raw = RAW_STOP1;
                            2: raw = RAW_STOP2;
                            default: raw = RAW_STOP3;
                        endcase
                    end
                    1: raw[k[0]*16 +: 16] = k[1] ? HALF_STOP1 : HALF_STOP0;
                    2: raw[k*8 +: 8] = $urandom_range(1) ? BYTE_STOP1 : BYTE_STOP0;
                    default: begin
                        addr = $urandom_range(1) ? ADDR_STOP : 16'h0000;
                        case (k)
                            0: cmd = {8'h00, BYTE_STOP0};
                            1: cmd = {8'h00, BYTE_STOP1};
                            2: cmd = HALF_STOP0;
                            default: cmd = HALF_STOP1;
                        endcase
                    end
                endcase
                it = frame_item(raw, addr, cmd, 1'b0);
            end else if (pick < 13) begin
                it = frame_item(raw, addr, cmd, 1'b1);
            end else if (pick < 17) begin
                // noise, often with a stop-like address but arbitrary command
                if ($urandom_range(1))
                    addr = $urandom_range(1) ? ADDR_STOP : 16'h0000;
                it = frame_item(raw, addr, cmd, 1'($urandom_range(1)));
            end else begin
                k = $urandom_range(99);
                if (k < 2)
                    now_ms = $urandom;
                else if (k < 10)
                    now_ms += $urandom_range(2000, 300);
                else
                    now_ms += $urandom_range(120);
                if ($urandom_range(99) < 12) opp_l_state = !opp_l_state;
                if ($urandom_range(99) < 12) opp_r_state = !opp_r_state;
                it = tick_item(now_ms, line_pick(tracker.edge_thr), line_pick(tracker.edge_thr),
                               opp_l_state, opp_r_state);
            end
            send_item(it);
        end
    endtask

    initial begin
        tracker = new();
        tracker.clear();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        now_ms          = '0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tuser  <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_wdata     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disarmed blink at both ends of the time range
        send_item(tick_item(32'd500, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'hFFFF_FFFF, 10'd0, 10'd0, 1'b1, 1'b1));
        // repeat flag with no earlier frame falls back to the fields
        send_item(frame_item(32'h0000_0000, 16'hFFFF, 16'hFFFF, 1'b1));
        // arm, initial spin right
        send_item(frame_item(RAW_START_R0, 16'h0000, 16'h0000, 1'b0));
        send_item(tick_item(32'd1000, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'd1010, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'd1360, 10'd1023, 10'd1023, 1'b0, 1'b0));
        // both edges: backup, spin, stop
        send_item(tick_item(32'd1400, 10'd0, 10'd0, 1'b0, 1'b0));
        send_item(tick_item(32'd1410, 10'd0, 10'd0, 1'b0, 1'b0));
        send_item(tick_item(32'd1660, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'd1960, 10'd1023, 10'd1023, 1'b0, 1'b0));
        // left edge just below threshold, right exactly at it
        send_item(tick_item(32'd2000, 10'd899, 10'd900, 1'b0, 1'b0));
        send_item(tick_item(32'd2010, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'd2160, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'd2460, 10'd1023, 10'd1023, 1'b0, 1'b0));
        // opponent debounce: left then both
        send_item(tick_item(32'd2500, 10'd1023, 10'd1023, 1'b1, 1'b0));
        send_item(tick_item(32'd2510, 10'd1023, 10'd1023, 1'b1, 1'b1));
        send_item(tick_item(32'd2520, 10'd1023, 10'd1023, 1'b1, 1'b1));
        // repeat reuses start, address plus command stops, start left
        send_item(frame_item(32'h1234_5678, 16'h0001, 16'h0002, 1'b1));
        send_item(frame_item(32'h0000_0000, ADDR_STOP, HALF_STOP0, 1'b0));
        send_item(frame_item(RAW_START_L1, 16'h0000, 16'h0000, 1'b0));
        // initial spin left across the time wrap
        send_item(tick_item(32'hFFFF_FF00, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'hFFFF_FF10, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'h0000_0010, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(tick_item(32'h0000_0070, 10'd1023, 10'd1023, 1'b0, 1'b0));
        send_item(frame_item(32'h0000_0000, 16'h0001, 16'h0001, 1'b1));
        now_ms = 32'h0000_0070;

        // default registers, free flowing
        run_random(150);
        settle();

        // upper extremes, zero durations, sender mostly idle
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_idle_pct = 87;
        run_random(150);
        settle();

        // lower extremes (no edge, debounce zero), longest durations, receiver stalls
        load_regs(16'hFC00, 16'hFFF0, 16'hFF00, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        run_random(150);
        settle();

        // arbitrary settings, both sides idling
        load_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(600)), 16'($urandom_range(600)),
                  16'($urandom_range(600)), 16'($urandom));
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        run_random(150);
        settle();

        // mid threshold, quickest debounce, short timers
        load_regs(16'd512, 16'd1, 16'd77, 16'd33, 16'($urandom_range(300)),
                  16'($urandom_range(300)), 16'($urandom_range(300)),
                  16'($urandom_range(300)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(200);
        settle();

        // back to the reset values, sender idle
        load_regs(16'd900, 16'd2, 16'd200, 16'd100, 16'd350, 16'd250, 16'd150, 16'd300);
        send_idle_pct = 87;
        run_random(150);
        settle();
        repeat (10) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.expected_words.size() == 0)
            $display("sumo_maneuver_sequencer: match");
        else
            $display("sumo_maneuver_sequencer: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sms_pkg.sv
rtl/sms_front.sv
rtl/sms_core.sv
rtl/sumo_maneuver_sequencer.sv
tb/tb_sumo_maneuver_sequencer.sv
